// ===== hw/rtl/pfrm_pkg.sv =====
package pfrm_pkg;

  localparam int FLOW_SLOTS  = 4;
  localparam int VOCAB_DEPTH = 32;
  localparam int COUNT_BITS  = 16;
  localparam int VALUE_BITS  = 32;

  localparam int FLOW_W    = 2;
  localparam int IDX_W     = (VOCAB_DEPTH > 1) ? $clog2(VOCAB_DEPTH) : 1;
  localparam int SIZE_W    = $clog2(VOCAB_DEPTH + 1);
  localparam int ADDR_W    = FLOW_W + IDX_W;
  localparam int MEM_DEPTH = 2 ** ADDR_W;

  typedef logic [COUNT_BITS-1:0]  cnt_t;
  typedef logic [VALUE_BITS-1:0]  val_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [SIZE_W-1:0]      size_t;
  typedef logic [VOCAB_DEPTH-1:0] seen_t;
  typedef logic [ADDR_W-1:0]      addr_t;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ADD    = 2'd1,
    OP_GET    = 2'd2,
    OP_REMOVE = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_RES   = 3'd1,
    ST_NO_FLOW  = 3'd2,
    ST_NO_VALUE = 3'd3,
    ST_IN_USE   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SLOT_FREE    = 2'd0,
    SLOT_LOADING = 2'd1,
    SLOT_ACTIVE  = 2'd2
  } slot_st_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  flow;
    logic [31:0] sample;
    logic        last;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] median;
  } out_word_t;

  typedef struct packed {
    val_t value;
    cnt_t count;
    cnt_t left;
    cnt_t right;
  } entry_t;

  typedef struct packed {
    logic found;
    idx_t idx;
  } nb_t;

  typedef enum logic [4:0] {
    C_NOP,
    C_LATCH,
    C_LOAD_INIT,
    C_SCAN_INIT,
    C_SCAN_RD,
    C_SCAN_STEP,
    C_SHIFT_INIT,
    C_SH_RD,
    C_SH_WR,
    C_LOAD_WR,
    C_ADD_W,
    C_RD_P,
    C_P,
    C_J,
    C_GET_RD,
    C_GET,
    C_REMOVE
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    set_st;
    status_t st;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    opcode_t  opcode;
    slot_st_t slot;
    logic     flow_bad;
    logic     scan_end;
    logic     ge;
    logic     eq;
    logic     full;
    logic     ovf;
    logic     mv;
    logic     at_pos;
    logic     out_busy;
  } sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DEC,
    S_SH,
    S_SH_WR,
    S_ADD_RDP,
    S_ADD_P,
    S_ADD_J,
    S_GET,
    S_OUT
  } ctrl_state_t;

  function automatic nb_t nb_below(seen_t seen, idx_t p);
    nb_t r;
    r = '0;
    for (int i = 0; i < VOCAB_DEPTH; i++) begin
      if (seen[i] && (i < int'(p))) begin
        r.found = 1'b1;
        r.idx   = idx_t'(i);
      end
    end
    return r;
  endfunction

  function automatic nb_t nb_above(seen_t seen, idx_t p);
    nb_t r;
    r = '0;
    for (int i = VOCAB_DEPTH - 1; i >= 0; i--) begin
      if (seen[i] && (i > int'(p))) begin
        r.found = 1'b1;
        r.idx   = idx_t'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/pfrm_ctrl.sv =====
module pfrm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pfrm_pkg::sts_t  sts,
  output pfrm_pkg::cmd_t  cmd
);

  pfrm_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfrm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd.op     = pfrm_pkg::C_NOP;
    cmd.set_st = 1'b0;
    cmd.st     = pfrm_pkg::ST_OK;
    cmd.emit   = 1'b0;
    in_ready   = 1'b0;
    case (state_r)
      pfrm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = pfrm_pkg::C_LATCH;
          state_nxt = pfrm_pkg::S_DISP;
        end
      end
      pfrm_pkg::S_DISP: begin
        state_nxt  = pfrm_pkg::S_OUT;
        cmd.set_st = 1'b1;
        if (sts.flow_bad) begin
          cmd.st = pfrm_pkg::ST_NO_FLOW;
        end else begin
          case (sts.opcode)
            pfrm_pkg::OP_LOAD: begin
              if (sts.slot == pfrm_pkg::SLOT_ACTIVE) begin
                cmd.st = pfrm_pkg::ST_IN_USE;
              end else begin
                cmd.op    = pfrm_pkg::C_LOAD_INIT;
                state_nxt = pfrm_pkg::S_SCAN_RD;
              end
            end
            pfrm_pkg::OP_ADD: begin
              if (sts.slot != pfrm_pkg::SLOT_ACTIVE) begin
                cmd.st = pfrm_pkg::ST_NO_FLOW;
              end else begin
                cmd.op    = pfrm_pkg::C_SCAN_INIT;
                state_nxt = pfrm_pkg::S_SCAN_RD;
              end
            end
            pfrm_pkg::OP_GET: begin
              if (sts.slot != pfrm_pkg::SLOT_ACTIVE) begin
                cmd.st = pfrm_pkg::ST_NO_FLOW;
              end else begin
                cmd.op    = pfrm_pkg::C_GET_RD;
                state_nxt = pfrm_pkg::S_GET;
              end
            end
            default: begin
              if (sts.slot == pfrm_pkg::SLOT_FREE) begin
                cmd.st = pfrm_pkg::ST_NO_FLOW;
              end else begin
                cmd.op = pfrm_pkg::C_REMOVE;
              end
            end
          endcase
        end
      end
      pfrm_pkg::S_SCAN_RD: begin
        cmd.op    = pfrm_pkg::C_SCAN_RD;
        state_nxt = sts.scan_end ? pfrm_pkg::S_DEC : pfrm_pkg::S_SCAN_CMP;
      end
      pfrm_pkg::S_SCAN_CMP: begin
        cmd.op    = pfrm_pkg::C_SCAN_STEP;
        state_nxt = sts.ge ? pfrm_pkg::S_DEC : pfrm_pkg::S_SCAN_RD;
      end
      pfrm_pkg::S_DEC: begin
        state_nxt = pfrm_pkg::S_OUT;
        if (sts.opcode == pfrm_pkg::OP_LOAD) begin
          if (sts.eq || sts.full) begin
            cmd.set_st = 1'b1;
            cmd.st     = pfrm_pkg::ST_NO_RES;
          end else begin
            cmd.op    = pfrm_pkg::C_SHIFT_INIT;
            state_nxt = pfrm_pkg::S_SH;
          end
        end else begin
          if (!sts.eq) begin
            cmd.set_st = 1'b1;
            cmd.st     = pfrm_pkg::ST_NO_VALUE;
          end else if (sts.ovf) begin
            cmd.set_st = 1'b1;
            cmd.st     = pfrm_pkg::ST_NO_RES;
          end else begin
            cmd.op    = pfrm_pkg::C_ADD_W;
            state_nxt = pfrm_pkg::S_ADD_RDP;
          end
        end
      end
      pfrm_pkg::S_SH: begin
        if (sts.at_pos) begin
          cmd.op    = pfrm_pkg::C_LOAD_WR;
          state_nxt = pfrm_pkg::S_OUT;
        end else begin
          cmd.op    = pfrm_pkg::C_SH_RD;
          state_nxt = pfrm_pkg::S_SH_WR;
        end
      end
      pfrm_pkg::S_SH_WR: begin
        cmd.op    = pfrm_pkg::C_SH_WR;
        state_nxt = pfrm_pkg::S_SH;
      end
      pfrm_pkg::S_ADD_RDP: begin
        cmd.op    = pfrm_pkg::C_RD_P;
        state_nxt = pfrm_pkg::S_ADD_P;
      end
      pfrm_pkg::S_ADD_P: begin
        cmd.op    = pfrm_pkg::C_P;
        state_nxt = sts.mv ? pfrm_pkg::S_ADD_J : pfrm_pkg::S_OUT;
      end
      pfrm_pkg::S_ADD_J: begin
        cmd.op    = pfrm_pkg::C_J;
        state_nxt = pfrm_pkg::S_OUT;
      end
      pfrm_pkg::S_GET: begin
        cmd.op    = pfrm_pkg::C_GET;
        state_nxt = pfrm_pkg::S_OUT;
      end
      pfrm_pkg::S_OUT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = pfrm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pfrm_pkg::S_IDLE;
      end
    endcase
  end

  a_emit_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> state_r == pfrm_pkg::S_OUT)
    else $error("result emitted outside output state");

  a_out_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> in_ready)
    else $error("not idle after result");

  a_latch_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == pfrm_pkg::C_LATCH |=> state_r == pfrm_pkg::S_DISP)
    else $error("latch without dispatch");

endmodule

// ===== hw/rtl/pfrm_dpath.sv =====
module pfrm_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  pfrm_pkg::in_word_t  in_word,
  input  pfrm_pkg::cmd_t      cmd,
  output pfrm_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_ready,
  output pfrm_pkg::out_word_t out_word
);

  pfrm_pkg::in_word_t  item_r;
  pfrm_pkg::slot_st_t  slot_r [pfrm_pkg::FLOW_SLOTS];
  pfrm_pkg::size_t     size_r [pfrm_pkg::FLOW_SLOTS];
  pfrm_pkg::seen_t     seen_r [pfrm_pkg::FLOW_SLOTS];
  pfrm_pkg::idx_t      ptr_r  [pfrm_pkg::FLOW_SLOTS];
  pfrm_pkg::size_t     idx_r;
  pfrm_pkg::size_t     pos_r;
  logic                eq_r;
  logic                dir_r;
  pfrm_pkg::entry_t    ent_r;
  pfrm_pkg::status_t   st_r;
  pfrm_pkg::val_t      med_r;
  logic                out_valid_r;
  pfrm_pkg::out_word_t out_r;

  pfrm_pkg::entry_t    mem [pfrm_pkg::MEM_DEPTH];
  pfrm_pkg::entry_t    rdata_r;

  logic [1:0]          fl;
  pfrm_pkg::val_t      v;
  pfrm_pkg::seen_t     seen_cur;
  pfrm_pkg::idx_t      ptr_cur;
  pfrm_pkg::size_t     size_cur;
  pfrm_pkg::nb_t       lo, hi;
  logic                p_eq, p_lt, mv_lo, mv_hi;
  logic                mem_we, mem_re;
  pfrm_pkg::idx_t      wr_idx, rd_idx;
  pfrm_pkg::entry_t    wdata;
  pfrm_pkg::entry_t    ent_inc;

  assign fl       = item_r.flow;
  assign v        = item_r.sample[pfrm_pkg::VALUE_BITS-1:0];
  assign seen_cur = seen_r[fl];
  assign ptr_cur  = ptr_r[fl];
  assign size_cur = size_r[fl];

  assign lo    = pfrm_pkg::nb_below(seen_cur, ptr_cur);
  assign hi    = pfrm_pkg::nb_above(seen_cur, ptr_cur);
  assign p_eq  = (v == rdata_r.value);
  assign p_lt  = (v < rdata_r.value);
  assign mv_lo = p_lt && (rdata_r.left == pfrm_pkg::cnt_t'(1)) && lo.found;
  assign mv_hi = !p_eq && !p_lt && (rdata_r.right == '0) && hi.found;

  always_comb begin
    ent_inc       = ent_r;
    ent_inc.count = ent_r.count + pfrm_pkg::cnt_t'(2);
  end

  assign sts.opcode   = pfrm_pkg::opcode_t'(item_r.opcode);
  assign sts.slot     = slot_r[fl];
  assign sts.flow_bad = int'(fl) >= pfrm_pkg::FLOW_SLOTS;
  assign sts.scan_end = idx_r >= size_cur;
  assign sts.ge       = rdata_r.value >= v;
  assign sts.eq       = eq_r;
  assign sts.full     = size_cur >= pfrm_pkg::size_t'(pfrm_pkg::VOCAB_DEPTH);
  assign sts.ovf      = ent_r.count >= ~pfrm_pkg::cnt_t'(1);
  assign sts.mv       = mv_lo || mv_hi;
  assign sts.at_pos   = idx_r == pos_r;
  assign sts.out_busy = out_valid_r && !out_ready;

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    wr_idx = ptr_cur;
    rd_idx = ptr_cur;
    wdata  = rdata_r;
    case (cmd.op)
      pfrm_pkg::C_SCAN_RD: begin
        mem_re = !sts.scan_end;
        rd_idx = idx_r[pfrm_pkg::IDX_W-1:0];
      end
      pfrm_pkg::C_SH_RD: begin
        mem_re = 1'b1;
        rd_idx = pfrm_pkg::idx_t'(idx_r - pfrm_pkg::size_t'(1));
      end
      pfrm_pkg::C_SH_WR: begin
        mem_we = 1'b1;
        wr_idx = idx_r[pfrm_pkg::IDX_W-1:0];
      end
      pfrm_pkg::C_LOAD_WR: begin
        mem_we = 1'b1;
        wr_idx = pos_r[pfrm_pkg::IDX_W-1:0];
        wdata  = '{value: v, count: '0, left: '0, right: '0};
      end
      pfrm_pkg::C_ADD_W: begin
        mem_we = 1'b1;
        wr_idx = pos_r[pfrm_pkg::IDX_W-1:0];
        wdata  = ent_inc;
      end
      pfrm_pkg::C_RD_P, pfrm_pkg::C_GET_RD: begin
        mem_re = 1'b1;
      end
      pfrm_pkg::C_P: begin
        if (mv_lo) begin
          mem_re = 1'b1;
          rd_idx = lo.idx;
        end else if (mv_hi) begin
          mem_re = 1'b1;
          rd_idx = hi.idx;
        end else if (p_eq) begin
          mem_we      = 1'b1;
          wdata.left  = rdata_r.left + pfrm_pkg::cnt_t'(1);
          wdata.right = rdata_r.right + pfrm_pkg::cnt_t'(1);
        end else if (p_lt && (rdata_r.left != pfrm_pkg::cnt_t'(1))) begin
          mem_we      = 1'b1;
          wdata.left  = rdata_r.left - pfrm_pkg::cnt_t'(1);
          wdata.right = rdata_r.right + pfrm_pkg::cnt_t'(1);
        end else if (!p_lt && !p_eq && (rdata_r.right != '0)) begin
          mem_we      = 1'b1;
          wdata.left  = rdata_r.left + pfrm_pkg::cnt_t'(1);
          wdata.right = rdata_r.right - pfrm_pkg::cnt_t'(1);
        end
      end
      pfrm_pkg::C_J: begin
        mem_we = 1'b1;
        if (dir_r) begin
          wdata.left  = pfrm_pkg::cnt_t'(1);
          wdata.right = rdata_r.count - pfrm_pkg::cnt_t'(1);
        end else begin
          wdata.left  = rdata_r.count;
          wdata.right = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{fl, wr_idx}] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[{fl, rd_idx}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < pfrm_pkg::FLOW_SLOTS; i++) begin
        slot_r[i] <= pfrm_pkg::SLOT_FREE;
        size_r[i] <= '0;
        seen_r[i] <= '0;
        ptr_r[i]  <= '0;
      end
    end else begin
      case (cmd.op)
        pfrm_pkg::C_LATCH: begin
          item_r <= in_word;
          med_r  <= '0;
          eq_r   <= 1'b0;
        end
        pfrm_pkg::C_LOAD_INIT: begin
          if (slot_r[fl] == pfrm_pkg::SLOT_FREE) begin
            slot_r[fl] <= pfrm_pkg::SLOT_LOADING;
            size_r[fl] <= '0;
            seen_r[fl] <= '0;
            ptr_r[fl]  <= '0;
          end
          idx_r <= '0;
          eq_r  <= 1'b0;
        end
        pfrm_pkg::C_SCAN_INIT: begin
          idx_r <= '0;
          eq_r  <= 1'b0;
        end
        pfrm_pkg::C_SCAN_RD: begin
          if (sts.scan_end) begin
            pos_r <= idx_r;
          end
        end
        pfrm_pkg::C_SCAN_STEP: begin
          ent_r <= rdata_r;
          if (sts.ge) begin
            pos_r <= idx_r;
            eq_r  <= (rdata_r.value == v);
          end else begin
            idx_r <= idx_r + pfrm_pkg::size_t'(1);
          end
        end
        pfrm_pkg::C_SHIFT_INIT: begin
          idx_r <= size_cur;
        end
        pfrm_pkg::C_SH_WR: begin
          idx_r <= idx_r - pfrm_pkg::size_t'(1);
        end
        pfrm_pkg::C_LOAD_WR: begin
          size_r[fl] <= size_cur + pfrm_pkg::size_t'(1);
          if (item_r.last) begin
            slot_r[fl] <= pfrm_pkg::SLOT_ACTIVE;
          end
        end
        pfrm_pkg::C_ADD_W: begin
          seen_r[fl] <= seen_cur | (pfrm_pkg::seen_t'(1) << pos_r[pfrm_pkg::IDX_W-1:0]);
          if (seen_cur == '0) begin
            ptr_r[fl] <= pos_r[pfrm_pkg::IDX_W-1:0];
          end
        end
        pfrm_pkg::C_P: begin
          if (mv_lo) begin
            ptr_r[fl] <= lo.idx;
            dir_r     <= 1'b0;
          end else if (mv_hi) begin
            ptr_r[fl] <= hi.idx;
            dir_r     <= 1'b1;
          end
        end
        pfrm_pkg::C_GET: begin
          med_r <= rdata_r.value;
        end
        pfrm_pkg::C_REMOVE: begin
          slot_r[fl] <= pfrm_pkg::SLOT_FREE;
          size_r[fl] <= '0;
          seen_r[fl] <= '0;
          ptr_r[fl]  <= '0;
        end
        default: begin
        end
      endcase
      if (cmd.set_st) begin
        st_r <= cmd.st;
      end else if (cmd.op == pfrm_pkg::C_LOAD_WR || cmd.op == pfrm_pkg::C_J ||
                   cmd.op == pfrm_pkg::C_GET || cmd.op == pfrm_pkg::C_REMOVE ||
                   (cmd.op == pfrm_pkg::C_P && !sts.mv)) begin
        st_r <= pfrm_pkg::ST_OK;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        out_r       <= '{status: st_r, median: 32'(med_r)};
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  a_ptr_in_vocab: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r[fl] == pfrm_pkg::SLOT_ACTIVE |-> pfrm_pkg::size_t'(ptr_cur) < size_cur)
    else $error("median index beyond vocabulary");

  a_seen_in_vocab: assert property (@(posedge clk) disable iff (!rst_n)
    (seen_cur >> size_cur) == '0)
    else $error("seen bit beyond vocabulary");

  a_shift_above_pos: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == pfrm_pkg::C_SH_WR |-> idx_r > pos_r)
    else $error("shift below insert point");

  a_no_emit_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.out_busy)
    else $error("result overwrites pending word");

endmodule

// ===== hw/rtl/per_flow_running_median_unit.sv =====
// per-flow running median over a sorted vocabulary of up to 32 values
// input channel in_valid/in_ready/in_word: one word per request (load,
// add, get, remove) for one of four flow slots
// result channel out_valid/out_ready/out_word: exactly one word per
// request, status plus median (median nonzero only on a good get)
// one request is in work at a time; out_valid rises in the same cycle
// that in_ready returns high; a load scans the entries below the value
// and shifts those above it up one place (appending at the end needs no
// shift), an add scans the entries below the sample, and a load or add
// can be refused after the scan
// the per-entry table is one memory with one read and one write port;
// the sorted scan and the insertion shift each take a read state and a
// compare or write state per entry through that port
// a new request is taken while a finished word waits on out_ready; its
// word is held back until the output register frees
// synchronous active-low reset frees all slots and empties the output;
// table memory needs no clearing, entries are written on load
module per_flow_running_median_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pfrm_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output pfrm_pkg::out_word_t out_word
);

  pfrm_pkg::cmd_t cmd;
  pfrm_pkg::sts_t sts;

  pfrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfrm_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

// ===== test/per_flow_running_median_unit_test.sv =====
module per_flow_running_median_unit_test;

  class median_scoreboard;
    logic [1:0]  slot_st [pfrm_pkg::FLOW_SLOTS];
    int          vsize [pfrm_pkg::FLOW_SLOTS];
    logic [31:0] seen [pfrm_pkg::FLOW_SLOTS];
    int          mptr [pfrm_pkg::FLOW_SLOTS];
    logic [31:0] vval [pfrm_pkg::FLOW_SLOTS][pfrm_pkg::VOCAB_DEPTH];
    logic [15:0] occ [pfrm_pkg::FLOW_SLOTS][pfrm_pkg::VOCAB_DEPTH];
    logic [15:0] ldist [pfrm_pkg::FLOW_SLOTS][pfrm_pkg::VOCAB_DEPTH];
    logic [15:0] rdist [pfrm_pkg::FLOW_SLOTS][pfrm_pkg::VOCAB_DEPTH];
    pfrm_pkg::out_word_t pending [$];
    int          mismatches;
    int          checked;
    int          ok_gets;

    function new();
      for (int s = 0; s < pfrm_pkg::FLOW_SLOTS; s++) begin
        slot_st[s] = pfrm_pkg::SLOT_FREE;
        vsize[s] = 0;
        seen[s] = '0;
        mptr[s] = 0;
        for (int i = 0; i < pfrm_pkg::VOCAB_DEPTH; i++) begin
          vval[s][i] = '0;
          occ[s][i] = '0;
          ldist[s][i] = '0;
          rdist[s][i] = '0;
        end
      end
      mismatches = 0;
      checked = 0;
      ok_gets = 0;
    endfunction

    function pfrm_pkg::status_t load_value(int s, logic [31:0] v, logic fin);
      int n;
      int pos;
      if (slot_st[s] == pfrm_pkg::SLOT_ACTIVE) return pfrm_pkg::ST_IN_USE;
      if (slot_st[s] == pfrm_pkg::SLOT_FREE) begin
        vsize[s] = 0;
        seen[s] = '0;
        mptr[s] = 0;
        slot_st[s] = pfrm_pkg::SLOT_LOADING;
      end
      n = vsize[s];
      pos = 0;
      while (pos < n && vval[s][pos] < v) pos++;
      if (pos < n && vval[s][pos] == v) return pfrm_pkg::ST_NO_RES;
      if (n >= pfrm_pkg::VOCAB_DEPTH) return pfrm_pkg::ST_NO_RES;
      for (int i = n; i > pos; i--) begin
        vval[s][i] = vval[s][i-1];
        occ[s][i] = occ[s][i-1];
        ldist[s][i] = ldist[s][i-1];
        rdist[s][i] = rdist[s][i-1];
      end
      vval[s][pos] = v;
      occ[s][pos] = '0;
      ldist[s][pos] = '0;
      rdist[s][pos] = '0;
      vsize[s] = n + 1;
      if (fin) slot_st[s] = pfrm_pkg::SLOT_ACTIVE;
      return pfrm_pkg::ST_OK;
    endfunction

    function pfrm_pkg::status_t add_sample(int s, logic [31:0] v);
      int n;
      int pos;
      int p;
      if (slot_st[s] != pfrm_pkg::SLOT_ACTIVE) return pfrm_pkg::ST_NO_FLOW;
      n = vsize[s];
      pos = n;
      for (int i = 0; i < n; i++)
        if (vval[s][i] == v && pos == n) pos = i;
      if (pos >= n) return pfrm_pkg::ST_NO_VALUE;
      if (int'(occ[s][pos]) + 2 > 16'hffff) return pfrm_pkg::ST_NO_RES;
      if (seen[s] == 0) mptr[s] = pos;
      p = mptr[s];
      occ[s][pos] = occ[s][pos] + 16'd2;
      seen[s][pos] = 1'b1;
      if (v == vval[s][p]) begin
        ldist[s][p]++;
        rdist[s][p]++;
      end else if (v < vval[s][p]) begin
        if (ldist[s][p] == 16'd1) begin
          for (int j = p; j > 0; j--) begin
            if (seen[s][j-1]) begin
              mptr[s] = j - 1;
              ldist[s][j-1] = occ[s][j-1];
              rdist[s][j-1] = '0;
              break;
            end
          end
        end else begin
          ldist[s][p]--;
          rdist[s][p]++;
        end
      end else begin
        if (rdist[s][p] == 16'd0) begin
          for (int j = p + 1; j < n; j++) begin
            if (seen[s][j]) begin
              mptr[s] = j;
              ldist[s][j] = 16'd1;
              rdist[s][j] = occ[s][j] - 16'd1;
              break;
            end
          end
        end else begin
          ldist[s][p]++;
          rdist[s][p]--;
        end
      end
      return pfrm_pkg::ST_OK;
    endfunction

    function void note_input(pfrm_pkg::in_word_t w);
      pfrm_pkg::out_word_t r;
      int s;
      s = w.flow;
      r.status = pfrm_pkg::ST_OK;
      r.median = '0;
      case (pfrm_pkg::opcode_t'(w.opcode))
        pfrm_pkg::OP_LOAD: r.status = load_value(s, w.sample, w.last);
        pfrm_pkg::OP_ADD:  r.status = add_sample(s, w.sample);
        pfrm_pkg::OP_GET: begin
          if (slot_st[s] != pfrm_pkg::SLOT_ACTIVE) r.status = pfrm_pkg::ST_NO_FLOW;
          else r.median = vval[s][mptr[s]];
        end
        default: begin
          if (slot_st[s] == pfrm_pkg::SLOT_FREE) r.status = pfrm_pkg::ST_NO_FLOW;
          else begin
            slot_st[s] = pfrm_pkg::SLOT_FREE;
            vsize[s] = 0;
            seen[s] = '0;
            mptr[s] = 0;
          end
        end
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(pfrm_pkg::out_word_t got);
      pfrm_pkg::out_word_t exp_w;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: status %0d median %h",
                                       got.status, got.median);
        return;
      end
      exp_w = pending.pop_front();
      if (exp_w.status == pfrm_pkg::ST_OK && exp_w.median != 0) ok_gets++;
      if (got !== exp_w) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status %0d median %h, got status %0d median %h",
                   exp_w.status, exp_w.median, got.status, got.median);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  pfrm_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  pfrm_pkg::out_word_t out_word;

  median_scoreboard sb = new();
  int sent = 0;
  bit calm = 0;
  logic [31:0] vocab [pfrm_pkg::FLOW_SLOTS][$];

  per_flow_running_median_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
  );

  always #5 clk = ~clk;

  task automatic send_word(logic [1:0] op, logic [1:0] fl, logic [31:0] smp, logic lst);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= '{opcode: op, flow: fl, sample: smp, last: lst};
    do @(posedge clk); while (!in_ready);
    sb.note_input('{opcode: op, flow: fl, sample: smp, last: lst});
    sent++;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hffffffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic build_flow(int f, int n);
    logic [31:0] v;
    vocab[f].delete();
    for (int i = 0; i < n; i++) begin
      v = ($urandom_range(0, 3) == 0) ? rand_value() : $urandom_range(0, 60);
      if ($urandom_range(0, 15) == 0 && vocab[f].size() > 0) v = vocab[f][0];
      vocab[f].push_back(v);
      send_word(pfrm_pkg::OP_LOAD, f[1:0], v, i == n - 1);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_word);
  end

  initial begin
    int stall;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int f;
    int r;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed part
    send_word(pfrm_pkg::OP_GET, 2'd0, 32'h0, 1'b0);
    send_word(pfrm_pkg::OP_REMOVE, 2'd1, 32'h0, 1'b0);
    send_word(pfrm_pkg::OP_ADD, 2'd2, 32'h5, 1'b0);
    send_word(pfrm_pkg::OP_LOAD, 2'd3, 32'hffffffff, 1'b0);
    send_word(pfrm_pkg::OP_LOAD, 2'd3, 32'hffffffff, 1'b1);
    send_word(pfrm_pkg::OP_GET, 2'd3, 32'h0, 1'b0);
    send_word(pfrm_pkg::OP_REMOVE, 2'd3, 32'h0, 1'b0);
    send_word(pfrm_pkg::OP_LOAD, 2'd0, 32'h0, 1'b0);
    send_word(pfrm_pkg::OP_LOAD, 2'd0, 32'hffffffff, 1'b0);
    send_word(pfrm_pkg::OP_LOAD, 2'd0, 32'h80000000, 1'b1);
    send_word(pfrm_pkg::OP_LOAD, 2'd0, 32'h7, 1'b1);
    send_word(pfrm_pkg::OP_ADD, 2'd0, 32'h7, 1'b0);
    send_word(pfrm_pkg::OP_ADD, 2'd0, 32'hffffffff, 1'b0);
    send_word(pfrm_pkg::OP_ADD, 2'd0, 32'hffffffff, 1'b0);
    send_word(pfrm_pkg::OP_ADD, 2'd0, 32'h0, 1'b0);
    send_word(pfrm_pkg::OP_GET, 2'd0, 32'h0, 1'b0);
    send_word(pfrm_pkg::OP_REMOVE, 2'd0, 32'h0, 1'b0);
    // full vocabulary, no gaps
    calm = 1;
    for (int i = 0; i < 33; i++)
      send_word(pfrm_pkg::OP_LOAD, 2'd1, 32'(i * 3 + 1), i == 32);
    send_word(pfrm_pkg::OP_ADD, 2'd1, 32'h1, 1'b0);
    send_word(pfrm_pkg::OP_ADD, 2'd1, 32'd94, 1'b0);
    send_word(pfrm_pkg::OP_GET, 2'd1, 32'h0, 1'b0);
    send_word(pfrm_pkg::OP_REMOVE, 2'd1, 32'h0, 1'b0);
    calm = 0;
    // random part, mostly well formed flows
    while (sent < 1400) begin
      f = $urandom_range(0, 3);
      if (sb.slot_st[f] != pfrm_pkg::SLOT_ACTIVE) begin
        if (sb.slot_st[f] == pfrm_pkg::SLOT_LOADING)
          send_word(pfrm_pkg::OP_REMOVE, f[1:0], 32'h0, 1'b0);
        build_flow(f, ($urandom_range(0, 9) == 0) ? $urandom_range(20, 34)
                                                : $urandom_range(1, 8));
      end
      r = $urandom_range(0, 99);
      if (r < 60)
        send_word(pfrm_pkg::OP_ADD, f[1:0],
                  ($urandom_range(0, 9) == 0) ? rand_value()
                  : vocab[f][$urandom_range(0, vocab[f].size() - 1)], 1'b0);
      else if (r < 85)
        send_word(pfrm_pkg::OP_GET, f[1:0], $urandom(), $urandom_range(0, 1));
      else if (r < 92)
        send_word(pfrm_pkg::OP_LOAD, f[1:0], rand_value(), $urandom_range(0, 1));
      else
        send_word(pfrm_pkg::OP_REMOVE, f[1:0], $urandom(), $urandom_range(0, 1));
    end
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d words over four flow slots, checked %0d results, %0d nonzero medians",
             sent, sb.checked, sb.ok_gets);
    $display("mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
